[rtl/cpe_pkg.sv]
// Shared constants, types and Q8.24 arithmetic helpers for the complex
// polynomial evaluator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpe_pkg;

  localparam int MAX_TERMS = 64;
  localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int LEN_W     = $clog2(MAX_TERMS + 1);
  localparam int IDX_W     = 8;
  localparam int TC_W      = 7;
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 24;
  localparam int PROD_W    = 2 * DATA_W - FRAC_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int ENTRY_W   = 2 * DATA_W;
  localparam int CMP_W     = (LEN_W > IDX_W) ? ((LEN_W > TC_W) ? LEN_W : TC_W)
                                             : ((IDX_W > TC_W) ? IDX_W : TC_W);

  // front-to-back command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TC_W-1:0]          TERM_COUNT_RESET = TC_W'(64);
  localparam logic signed [DATA_W-1:0] ONE_Q   = DATA_W'(64'(1) << FRAC_W);
  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_READ = 2'd2,
    CMD_EVAL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  // One classified command as it sits in the queue
  typedef struct packed {
    cmd_t                      cmd;
    logic                      in_range;  // index below length; length non-zero for eval
    logic [ADDR_W-1:0]         addr;
    logic [LEN_W-1:0]          len;
    logic signed [DATA_W-1:0]  val_re;
    logic signed [DATA_W-1:0]  val_im;
  } job_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [TC_W-1:0] tc);
    logic [CMP_W-1:0] t;
    logic [CMP_W-1:0] m;
    t = CMP_W'(tc);
    m = CMP_W'(MAX_TERMS);
    return (t < m) ? LEN_W'(t) : LEN_W'(m);
  endfunction

  function automatic logic idx_below(input logic [IDX_W-1:0] idx,
                                     input logic [LEN_W-1:0] len);
    return CMP_W'(idx) < CMP_W'(len);
  endfunction

  // Q8.24 product, floor of the exact product
  function automatic logic signed [PROD_W-1:0] qmul(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    logic signed [2*DATA_W-1:0] p;
    p = a * b;
    return p[2*DATA_W-1:FRAC_W];
  endfunction

  function automatic logic sat_ovf(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){v[DATA_W-1]}};
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    if (sat_ovf(v)) begin
      return v[SUM_W-1] ? SAT_MIN : SAT_MAX;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/cpe_ram.sv]
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cpe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/cpe_front.sv]
// Front end: accepts commands, classifies them against the current length and
// holds them in a two-entry queue for the back end. Uses cpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpe_front
  import cpe_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [TC_W-1:0]          term_count,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_command,
  input  wire logic [IDX_W-1:0]         in_term_index,
  input  wire logic signed [DATA_W-1:0] in_value_real,
  input  wire logic signed [DATA_W-1:0] in_value_imag,
  output logic                          job_valid,
  output job_t                          job,
  input  wire logic                     job_pop
);

  job_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push;
  job_t              cls;
  logic [LEN_W-1:0]  len;

  assign len = eff_len(term_count);

  always_comb begin
    cls.cmd    = cmd_t'(in_command);
    cls.addr   = in_term_index[ADDR_W-1:0];
    cls.len    = len;
    cls.val_re = in_value_real;
    cls.val_im = in_value_imag;
    if (cls.cmd == CMD_EVAL) begin
      cls.in_range = (len != '0);
    end else begin
      cls.in_range = idx_below(in_term_index, len);
    end
  end

  assign in_stall  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign job_valid = (count_r != '0);
  assign job       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        q_r[wr_ptr_r] <= cls;
        wr_ptr_r      <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_r + QPTR_W'(1);
      end
      if (job_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                           : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !job_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (!push && job_pop) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/cpe_back.sv]
// Back end: runs queued commands against the coefficient RAM, including the
// S_EV_MUL/S_EV_ADD evaluation loop per term, and owns the output register.
// Uses cpe_pkg and cpe_ram.
`timescale 1ns / 1ps
`default_nettype none

module cpe_back
  import cpe_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                job_valid,
  input  wire job_t                job,
  output logic                     job_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [DATA_W-1:0] out_result_real,
  output logic signed [DATA_W-1:0] out_result_imag,
  output logic [1:0]               out_status
);

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_READ, S_EV_MUL, S_EV_ADD, S_EV_FIN, S_DONE
  } state_t;

  state_t                    state_r;
  logic [MAX_TERMS-1:0]      valid_r;
  logic                      rvalid_r;
  logic [ENTRY_W-1:0]        rdata;

  // current command
  logic [ADDR_W-1:0]         addr_r;
  logic [LEN_W-1:0]          len_r;
  logic signed [DATA_W-1:0]  val_re_r, val_im_r;

  // evaluation datapath
  logic [LEN_W-1:0]          i_r;
  logic signed [DATA_W-1:0]  p_re_r, p_im_r, acc_re_r, acc_im_r, term_re_r, term_im_r;
  logic signed [PROD_W-1:0]  m_crpr_r, m_cipi_r, m_crpi_r, m_cipr_r;
  logic signed [PROD_W-1:0]  m_przr_r, m_pizi_r, m_przi_r, m_pizr_r;
  logic                      sat_r;

  // result
  logic signed [DATA_W-1:0]  res_re_r, res_im_r;
  status_t                   res_st_r;
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_re_r, out_im_r;
  status_t                   out_st_r;

  logic                      ram_we, ram_re;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]        ram_wdata;

  logic signed [DATA_W-1:0]  c_re, c_im;
  logic signed [SUM_W-1:0]   add_re_nxt, add_im_nxt;
  logic signed [SUM_W-1:0]   acc_re_nxt, acc_im_nxt;
  logic signed [SUM_W-1:0]   t_re_nxt, t_im_nxt, p_re_nxt, p_im_nxt;
  logic [LEN_W-1:0]          i_nxt;
  logic                      more;
  logic                      out_free;

  cpe_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TERMS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // never-written entries read as zero
  assign c_re = rvalid_r ? $signed(rdata[ENTRY_W-1:DATA_W]) : '0;
  assign c_im = rvalid_r ? $signed(rdata[DATA_W-1:0])       : '0;

  assign add_re_nxt = SUM_W'(c_re) + SUM_W'(val_re_r);
  assign add_im_nxt = SUM_W'(c_im) + SUM_W'(val_im_r);
  assign acc_re_nxt = SUM_W'(acc_re_r) + SUM_W'(term_re_r);
  assign acc_im_nxt = SUM_W'(acc_im_r) + SUM_W'(term_im_r);
  assign t_re_nxt   = SUM_W'(m_crpr_r) - SUM_W'(m_cipi_r);
  assign t_im_nxt   = SUM_W'(m_crpi_r) + SUM_W'(m_cipr_r);
  assign p_re_nxt   = SUM_W'(m_przr_r) - SUM_W'(m_pizi_r);
  assign p_im_nxt   = SUM_W'(m_przi_r) + SUM_W'(m_pizr_r);
  assign i_nxt      = i_r + LEN_W'(1);
  assign more       = (i_nxt < len_r);

  assign job_pop  = (state_r == S_IDLE) && job_valid;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = {sat_val(add_re_nxt), sat_val(add_im_nxt)};
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid && job.in_range) begin
          unique case (job.cmd)
            CMD_SET: begin
              ram_we    = 1'b1;
              ram_waddr = job.addr;
              ram_wdata = {job.val_re, job.val_im};
            end
            CMD_ADD, CMD_READ: begin
              ram_re    = 1'b1;
              ram_raddr = job.addr;
            end
            CMD_EVAL: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
            end
            default: ;
          endcase
        end
      end
      S_ADD: begin
        ram_we = 1'b1;
      end
      S_EV_ADD: begin
        ram_re    = more;
        ram_raddr = i_nxt[ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rvalid_r <= valid_r[ram_raddr];
      end
      // a waiting result is reloaded in S_DONE instead
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            addr_r    <= job.addr;
            len_r     <= job.len;
            val_re_r  <= job.val_re;
            val_im_r  <= job.val_im;
            res_re_r  <= '0;
            res_im_r  <= '0;
            res_st_r  <= (!job.in_range && job.cmd == CMD_READ) ? ST_RANGE : ST_OK;
            i_r       <= '0;
            p_re_r    <= ONE_Q;
            p_im_r    <= '0;
            acc_re_r  <= '0;
            acc_im_r  <= '0;
            term_re_r <= '0;
            term_im_r <= '0;
            sat_r     <= 1'b0;
            if (job.in_range) begin
              unique case (job.cmd)
                CMD_ADD:  state_r <= S_ADD;
                CMD_READ: state_r <= S_READ;
                CMD_EVAL: state_r <= S_EV_MUL;
                default:  state_r <= S_DONE;
              endcase
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_ADD: begin
          if (sat_ovf(add_re_nxt) || sat_ovf(add_im_nxt)) begin
            res_st_r <= ST_SAT;
          end
          state_r <= S_DONE;
        end
        S_READ: begin
          res_re_r <= c_re;
          res_im_r <= c_im;
          state_r  <= S_DONE;
        end
        S_EV_MUL: begin
          // products for term i and for the next power; fold in term i-1
          m_crpr_r <= qmul(c_re, p_re_r);
          m_cipi_r <= qmul(c_im, p_im_r);
          m_crpi_r <= qmul(c_re, p_im_r);
          m_cipr_r <= qmul(c_im, p_re_r);
          m_przr_r <= qmul(p_re_r, val_re_r);
          m_pizi_r <= qmul(p_im_r, val_im_r);
          m_przi_r <= qmul(p_re_r, val_im_r);
          m_pizr_r <= qmul(p_im_r, val_re_r);
          acc_re_r <= sat_val(acc_re_nxt);
          acc_im_r <= sat_val(acc_im_nxt);
          if (sat_ovf(acc_re_nxt) || sat_ovf(acc_im_nxt)) begin
            sat_r <= 1'b1;
          end
          state_r <= S_EV_ADD;
        end
        S_EV_ADD: begin
          term_re_r <= sat_val(t_re_nxt);
          term_im_r <= sat_val(t_im_nxt);
          if (sat_ovf(t_re_nxt) || sat_ovf(t_im_nxt) ||
              (more && (sat_ovf(p_re_nxt) || sat_ovf(p_im_nxt)))) begin
            sat_r <= 1'b1;
          end
          if (more) begin
            p_re_r  <= sat_val(p_re_nxt);
            p_im_r  <= sat_val(p_im_nxt);
            i_r     <= i_nxt;
            state_r <= S_EV_MUL;
          end else begin
            state_r <= S_EV_FIN;
          end
        end
        S_EV_FIN: begin
          res_re_r <= sat_val(acc_re_nxt);
          res_im_r <= sat_val(acc_im_nxt);
          if (sat_r || sat_ovf(acc_re_nxt) || sat_ovf(acc_im_nxt)) begin
            res_st_r <= ST_SAT;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_re_r    <= res_re_r;
            out_im_r    <= res_im_r;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_real = out_re_r;
  assign out_result_imag = out_im_r;
  assign out_status      = out_st_r;

endmodule

`default_nettype wire

[rtl/complex_polynomial_evaluator_top.sv]
// Top level of the complex polynomial evaluator: length register, front-end
// queue and back-end execution unit. Uses cpe_pkg, cpe_front and cpe_back.
// Usage
//   Input channel (in_valid / in_stall): one command per transfer - set, add
//   to, or read one Q8.24 complex coefficient, or evaluate sum c[i]*z^i at z.
//   Output channel (out_valid / out_stall): exactly one result per command,
//   in command order; zero data for set/add, status flags range or saturation.
//   Config channel (cfg_valid / cfg_ready): writes term_count, the number of
//   coefficients in use; only to be written while the block is idle.
// Sequence
//   A set passes from the queue through S_IDLE and S_DONE into the output
//   register; add and read also pass S_ADD or S_READ. Evaluation of L terms
//   (L = min(term_count, 64)) loops per term through a multiply stage and a
//   combine/saturate stage for the power recurrence z^(i+1) = z^i * z.
//   The two-entry queue lets up to two further commands transfer in while one
//   runs; a finished result waits in the output register.
// Reset
//   Synchronous, active low: term_count returns to 64, queue and output are
//   emptied and every coefficient reads as zero until written again.
// Stalls
//   When out_stall is held, the finished result stays put, the back end
//   waits, and in_stall rises once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module complex_polynomial_evaluator_top
  import cpe_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [TC_W-1:0]          cfg_term_count,
  // commands
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_command,
  input  wire logic [IDX_W-1:0]         in_term_index,
  input  wire logic signed [DATA_W-1:0] in_value_real,
  input  wire logic signed [DATA_W-1:0] in_value_imag,
  // results
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_result_real,
  output logic signed [DATA_W-1:0]      out_result_imag,
  output logic [1:0]                    out_status
);

  logic [TC_W-1:0] term_count_r;
  logic            job_valid;
  job_t            job;
  logic            job_pop;

  // the length register takes a write in any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= TERM_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      term_count_r <= cfg_term_count;
    end
  end

  // classify and queue commands; the length is sampled here, per command
  cpe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .term_count    (term_count_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_term_index (in_term_index),
    .in_value_real (in_value_real),
    .in_value_imag (in_value_imag),
    .job_valid     (job_valid),
    .job           (job),
    .job_pop       (job_pop)
  );

  // execute against the coefficient RAM and drive the output register
  cpe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (job_valid),
    .job             (job),
    .job_pop         (job_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_real (out_result_real),
    .out_result_imag (out_result_imag),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire

[bench/complex_polynomial_evaluator_top_tb.sv]
// Self-checking bench for complex_polynomial_evaluator_top: directed table
// then randomised command traffic, scored against an in-bench Q8.24 predictor.
// Depends on cpe_pkg and the evaluator RTL only.
`timescale 1ns / 1ps

module complex_polynomial_evaluator_top_tb
  import cpe_pkg::*;
();

  // --------------------------------------------------------------------------
  // Bench constants
  // --------------------------------------------------------------------------
  localparam int ITEMS_PER_PHASE = 78;   // random commands per length setting
  localparam int LONG_HOLD       = 400;  // receiver hold-off, in cycles
  localparam int TAIL_CYCLES     = 200;  // quiet tail after the final drain

  // Length settings walked by the random part: full, tiny, empty, single,
  // above capacity (clips to 64), odd sizes and one below capacity.
  localparam logic [TC_W-1:0] PHASE_LEN [9] = '{
    7'd64, 7'd3, 7'd0, 7'd1, 7'd127, 7'd17, 7'd63, 7'd8, 7'd40
  };

  // One expected result as it comes out of the block
  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    status_t                  st;
  } result_t;

  // One row of the directed table. relen writes term_count to len first,
  // typed selects the hand-written result over the predictor's.
  typedef struct packed {
    logic              relen;
    logic [TC_W-1:0]   len;
    cmd_t              cmd;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic              typed;
    result_t           res;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // DUT connections
  // --------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [TC_W-1:0]          cfg_term_count;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               in_command;
  logic [IDX_W-1:0]         in_term_index;
  logic signed [DATA_W-1:0] in_value_real;
  logic signed [DATA_W-1:0] in_value_imag;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_result_real;
  logic signed [DATA_W-1:0] out_result_imag;
  logic [1:0]               out_status;

  complex_polynomial_evaluator_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_term_count  (cfg_term_count),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_term_index   (in_term_index),
    .in_value_real   (in_value_real),
    .in_value_imag   (in_value_imag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_real (out_result_real),
    .out_result_imag (out_result_imag),
    .out_status      (out_status)
  );

  // 20 ns period
  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: shadow coefficient table and length register
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] coef_re [MAX_TERMS];
  logic signed [DATA_W-1:0] coef_im [MAX_TERMS];
  logic [TC_W-1:0]          live_term_count;

  result_t pending_results [$];  // results owed by the block, oldest first
  int      mismatch_count = 0;
  int      hold_requests  = 0;   // bumped to ask the receiver for a long hold

  // Directed table. Hand-typed results only where they are obvious: fresh
  // store, range errors, writes that are dropped, saturating adds and reads
  // of a just-written extreme. Everything else is left to the predictor.
  stim_row_t directed_plan [26] = '{
    // fresh store: every in-range read is zero, 64 and above is out of range
    '{1'b0, 7'd0,   CMD_READ, 8'd0,   32'h0,        32'h0,        1'b1,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b0, 7'd0,   CMD_READ, 8'd63,  32'h0,        32'h0,        1'b1,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b0, 7'd0,   CMD_READ, 8'd64,  32'h0,        32'h0,        1'b1,
      '{32'h0, 32'h0, ST_RANGE}},
    '{1'b0, 7'd0,   CMD_READ, 8'd255, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
      '{32'h0, 32'h0, ST_RANGE}},
    '{1'b0, 7'd0,   CMD_EVAL, 8'd0,   ONE_Q,        32'h0,        1'b1,
      '{32'h0, 32'h0, ST_OK}},
    // extremes into entry 0, a dropped write beyond the length
    '{1'b0, 7'd0,   CMD_SET,  8'd0,   SAT_MAX,      SAT_MIN,      1'b1,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b0, 7'd0,   CMD_SET,  8'd255, 32'h1,        32'h1,        1'b1,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b0, 7'd0,   CMD_READ, 8'd0,   32'h0,        32'h0,        1'b1,
      '{SAT_MAX, SAT_MIN, ST_OK}},
    // add that saturates both parts, entry stays pinned at the rails
    '{1'b0, 7'd0,   CMD_ADD,  8'd0,   32'h1,        32'hffff_ffff, 1'b1,
      '{32'h0, 32'h0, ST_SAT}},
    '{1'b0, 7'd0,   CMD_READ, 8'd0,   32'h0,        32'h0,        1'b1,
      '{SAT_MAX, SAT_MIN, ST_OK}},
    // opposite rail added: lands on -1 ulp both ways without saturating
    '{1'b0, 7'd0,   CMD_ADD,  8'd0,   SAT_MIN,      SAT_MAX,      1'b1,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b0, 7'd0,   CMD_ADD,  8'd200, 32'h7fff_0000, 32'h7fff_0000, 1'b1,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b0, 7'd0,   CMD_SET,  8'd1,   ONE_Q,        32'h0,        1'b1,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b0, 7'd0,   CMD_SET,  8'd63,  32'h0080_0000, 32'hff80_0000, 1'b1,
      '{32'h0, 32'h0, ST_OK}},
    // evaluations over the full table: modest z, then both rails
    '{1'b0, 7'd0,   CMD_EVAL, 8'd0,   32'h0080_0000, 32'h0040_0000, 1'b0,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b0, 7'd0,   CMD_EVAL, 8'd0,   SAT_MAX,      SAT_MAX,      1'b0,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b0, 7'd0,   CMD_EVAL, 8'd0,   SAT_MIN,      SAT_MIN,      1'b0,
      '{32'h0, 32'h0, ST_OK}},
    // empty polynomial: zero result, everything out of range
    '{1'b1, 7'd0,   CMD_EVAL, 8'd0,   SAT_MAX,      SAT_MIN,      1'b1,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b0, 7'd0,   CMD_READ, 8'd0,   32'h0,        32'h0,        1'b1,
      '{32'h0, 32'h0, ST_RANGE}},
    '{1'b0, 7'd0,   CMD_SET,  8'd0,   32'h1234_5678, 32'h9abc_def0, 1'b1,
      '{32'h0, 32'h0, ST_OK}},
    // one term: entry 0 survived the shrink, trailing power never formed
    '{1'b1, 7'd1,   CMD_READ, 8'd0,   32'h0,        32'h0,        1'b0,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b0, 7'd1,   CMD_EVAL, 8'd255, SAT_MAX,      SAT_MAX,      1'b0,
      '{32'h0, 32'h0, ST_OK}},
    // length above capacity clips to 64
    '{1'b1, 7'd127, CMD_READ, 8'd63,  32'h0,        32'h0,        1'b0,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b0, 7'd127, CMD_READ, 8'd64,  32'h0,        32'h0,        1'b1,
      '{32'h0, 32'h0, ST_RANGE}},
    '{1'b0, 7'd127, CMD_EVAL, 8'd9,   32'hff00_0000, 32'h0,        1'b0,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b1, 7'd2,   CMD_EVAL, 8'd128, ONE_Q,        ONE_Q,        1'b0,
      '{32'h0, 32'h0, ST_OK}}
  };

  // --------------------------------------------------------------------------
  // Q8.24 arithmetic for the predictor
  // --------------------------------------------------------------------------
  function automatic longint clamp32(input longint v, inout bit hit);
    if (v > longint'(SAT_MAX)) begin
      hit = 1'b1;
      return longint'(SAT_MAX);
    end
    if (v < longint'(SAT_MIN)) begin
      hit = 1'b1;
      return longint'(SAT_MIN);
    end
    return v;
  endfunction

  // floor of a*b / 2^24; operands are 32-bit so the product fits
  function automatic longint q_product(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> FRAC_W;
  endfunction

  // Result of one command; updates the shadow table as the block would
  function automatic result_t command_response(input cmd_t cmd,
                                               input logic [IDX_W-1:0] idx,
                                               input logic signed [DATA_W-1:0] vr,
                                               input logic signed [DATA_W-1:0] vi);
    result_t res;
    longint  len, acc_re, acc_im, pr, pi, tr, ti, nr, ni;
    bit      hit;
    res    = '0;
    hit    = 1'b0;
    acc_re = 0;
    acc_im = 0;
    len    = (live_term_count < MAX_TERMS) ? live_term_count : MAX_TERMS;
    case (cmd)
      CMD_SET: begin
        if (idx < len) begin
          coef_re[idx[ADDR_W-1:0]] = vr;
          coef_im[idx[ADDR_W-1:0]] = vi;
        end
      end
      CMD_ADD: begin
        if (idx < len) begin
          nr = clamp32(longint'(coef_re[idx[ADDR_W-1:0]]) + longint'(vr), hit);
          ni = clamp32(longint'(coef_im[idx[ADDR_W-1:0]]) + longint'(vi), hit);
          coef_re[idx[ADDR_W-1:0]] = nr[DATA_W-1:0];
          coef_im[idx[ADDR_W-1:0]] = ni[DATA_W-1:0];
        end
      end
      CMD_READ: begin
        if (idx < len) begin
          res.re = coef_re[idx[ADDR_W-1:0]];
          res.im = coef_im[idx[ADDR_W-1:0]];
        end else begin
          res.st = ST_RANGE;
        end
      end
      default: begin
        // power sum with a running z^i, starting at 1.0
        pr = longint'(ONE_Q);
        pi = 0;
        for (int i = 0; i < len; i++) begin
          tr = clamp32(q_product(coef_re[ADDR_W'(i)], pr) -
                       q_product(coef_im[ADDR_W'(i)], pi), hit);
          ti = clamp32(q_product(coef_re[ADDR_W'(i)], pi) +
                       q_product(coef_im[ADDR_W'(i)], pr), hit);
          acc_re = clamp32(acc_re + tr, hit);
          acc_im = clamp32(acc_im + ti, hit);
          // no power beyond the last term, so it cannot flag saturation
          if (i + 1 < len) begin
            nr = clamp32(q_product(pr, vr) - q_product(pi, vi), hit);
            ni = clamp32(q_product(pr, vi) + q_product(pi, vr), hit);
            pr = nr;
            pi = ni;
          end
        end
        res.re = acc_re[DATA_W-1:0];
        res.im = acc_im[DATA_W-1:0];
      end
    endcase
    if (hit && res.st == ST_OK) begin
      res.st = ST_SAT;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Scoring
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  // Every result transfer is checked against the oldest owed result
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with none owed: %h %h status %0d",
                                out_result_real, out_result_imag, out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_result_real !== want.re) begin
          flag_mismatch($sformatf("result_real %h, want %h", out_result_real, want.re));
        end
        if (out_result_imag !== want.im) begin
          flag_mismatch($sformatf("result_imag %h, want %h", out_result_imag, want.im));
        end
        if (out_status !== want.st) begin
          flag_mismatch($sformatf("status %0d, want %0d", out_status, want.st));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern redrawn when mode_left runs out (none, light, heavy,
  // alternate), plus a long hold-off on request. The hold is counted here so
  // the sender keeps offering commands while the block backs up and raises
  // in_stall.
  // --------------------------------------------------------------------------
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int holds_served;
    out_stall    = 1'b0;
    mode         = 0;
    mode_left    = 50;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = 50;
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offer one command from the next falling edge until it transfers. The
  // owed result is queued at the transfer edge; it cannot come back sooner.
  task automatic issue_command(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] re,
                               input logic [DATA_W-1:0] im,
                               input bit use_typed, input result_t typed);
    result_t want;
    want = command_response(cmd, idx, re, im);
    if (use_typed) begin
      want = typed;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_term_index <= idx;
    in_value_real <= re;
    in_value_imag <= im;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(want);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Stop offering and wait until every owed result has transferred
  task automatic drain_results(input int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Length register written only with the block idle
  task automatic write_term_count(input logic [TC_W-1:0] v);
    drain_results(8);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_term_count <= v;
    do @(posedge clk); while (!cfg_ready);
    live_term_count = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Q8.24 value: mostly within +/- half_span, sometimes any pattern or a rail
  function automatic logic [DATA_W-1:0] random_q(input logic [DATA_W-1:0] half_span);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return SAT_MAX;
          1:       return SAT_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2:    return $urandom;
      default: return $urandom_range(0, 2 * half_span - 1) - half_span;
    endcase
  endfunction

  // Random command: mostly in-range writes and reads plus evaluations at
  // points near the unit circle, some stray indices and wild values
  task automatic draw_command(output cmd_t cmd, output logic [IDX_W-1:0] idx,
                              output logic [DATA_W-1:0] re,
                              output logic [DATA_W-1:0] im);
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    len  = (live_term_count < MAX_TERMS) ? live_term_count : MAX_TERMS;
    cmd  = (pick < 30) ? CMD_SET : (pick < 50) ? CMD_ADD : (pick < 70) ? CMD_READ
                                                                      : CMD_EVAL;
    if (len > 0 && $urandom_range(0, 9) < 8) begin
      idx = IDX_W'($urandom_range(0, len - 1));
    end else begin
      idx = IDX_W'($urandom_range(0, 255));
    end
    if (cmd == CMD_EVAL) begin
      re = random_q(32'h0140_0000);  // |part| up to 1.25
      im = random_q(32'h0140_0000);
    end else begin
      re = random_q(32'h0400_0000);  // |part| up to 4.0
      im = random_q(32'h0400_0000);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int                burst_left;
    cmd_t              cmd;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;

    // every input known from time zero, reset held low before the first commands
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_term_count = '0;
    in_valid       = 1'b0;
    in_command     = CMD_SET;
    in_term_index  = '0;
    in_value_real  = '0;
    in_value_imag  = '0;
    for (int i = 0; i < MAX_TERMS; i++) begin
      coef_re[ADDR_W'(i)] = '0;
      coef_im[ADDR_W'(i)] = '0;
    end
    live_term_count = TERM_COUNT_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, back to back with no sender gaps
    write_term_count(TERM_COUNT_RESET);
    foreach (directed_plan[r]) begin
      if (directed_plan[r].relen) begin
        write_term_count(directed_plan[r].len);
      end
      issue_command(directed_plan[r].cmd, directed_plan[r].idx, directed_plan[r].re,
                    directed_plan[r].im, directed_plan[r].typed, directed_plan[r].res);
    end

    // random phases, one length setting each; sender in bursts with gaps
    for (int p = 0; p < $size(PHASE_LEN); p++) begin
      write_term_count(PHASE_LEN[p]);
      burst_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long receiver hold while commands keep coming: queue fills up
        if (n == 20 && (p == 0 || p == 5)) begin
          hold_requests++;
        end
        // sender pause until nothing is owed, mid-phase
        if (n == 50) begin
          drain_results(0);
        end
        if (burst_left == 0) begin
          idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9));
          burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        draw_command(cmd, idx, re, im);
        issue_command(cmd, idx, re, im, 1'b0, '0);
      end
    end

    // all owed results back, then a tail to catch anything spurious
    drain_results(TAIL_CYCLES);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, set well above the slowest legal run
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
rtl/cpe_pkg.sv
rtl/cpe_ram.sv
rtl/cpe_front.sv
rtl/cpe_back.sv
rtl/complex_polynomial_evaluator_top.sv
bench/complex_polynomial_evaluator_top_tb.sv
